/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
// ASSERT_CLK_RST: checked on the rising clock edge, disabled while reset is high.
// ASSERT_CLK: checked on every rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK_RST(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

`define ASSERT_CLK(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);

`else

`define ASSERT_CLK_RST(lbl, clk_s, rst_s, prop, msg)

`define ASSERT_CLK(lbl, clk_s, prop, msg)

`endif

`endif

/* rtl/cidfp_pkg.sv */
package cidfp_pkg;

  // Pool size at build time
  localparam int DEFAULT_MAX_COLORS = 64;

  // Field widths
  localparam int ID_W   = 7;
  localparam int CMD_W  = 2;
  localparam int APB_DW = 32;
  localparam int APB_AW = 2;

  // Register byte addresses
  localparam logic [APB_AW-1:0] REG_PALETTE_SIZE = 2'd0;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_RESTART = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_FREE    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

endpackage

/* rtl/cidfp_ram.sv */
module cidfp_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read returns old data on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/color_id_free_pool_unit.sv */
// Channel   | Handshake                          | Payload
// ----------+------------------------------------+--------------------------------------
// command   | start, busy (transfer: start&!busy)| cmd, color_id
// result    | done (one-cycle strobe)            | granted_id, free_accepted, free_count
// register  | APB psel/penable/pwrite, pready=1  | paddr, pwdata, prdata (palette_size)
//
// One command per cycle; busy stays low, so a command may be issued every cycle.
// The result strobe follows the transfer through the input register, then one pass
// of logic into the result register.
// The ring of returned IDs is a RAM with a registered read; its head entry is
// prefetched at the next head address, bypassed when the previous command wrote it.
// Reset (rst, synchronous) empties the pool and clears palette_size; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "assert_macros.svh"

module color_id_free_pool_unit
  import cidfp_pkg::*;
#(
  parameter int MAX_COLORS = DEFAULT_MAX_COLORS
) (
  input  logic              clk,
  input  logic              rst,
  // command
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [ID_W-1:0]   color_id,
  // result
  output logic              done,
  output logic [ID_W-1:0]   granted_id,
  output logic              free_accepted,
  output logic [ID_W-1:0]   free_count,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int IW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int CW = $clog2(MAX_COLORS + 1);

  localparam logic [CW+ID_W-1:0] MAX_W  = (CW+ID_W)'(MAX_COLORS);
  localparam logic [CW-1:0]      MAX_C  = CW'(MAX_COLORS);
  localparam logic [IW-1:0]      LAST_I = IW'(MAX_COLORS - 1);

  // ID (1-based) to mask / ring index
  function automatic logic [IW-1:0] id_to_idx(input logic [ID_W-1:0] id);
    logic [IW+ID_W-1:0] w;
    w = {{IW{1'b0}}, id - ID_W'(1)};
    return w[IW-1:0];
  endfunction

  // Register file
  logic [ID_W-1:0] palette_size;
  logic            reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;
  assign prdata = {{(APB_DW-ID_W){1'b0}}, palette_size};

  // Every paddr value decodes to the one register
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= '0;
    end else if (reg_wr && (paddr == REG_PALETTE_SIZE || paddr != REG_PALETTE_SIZE)) begin
      palette_size <= pwdata[ID_W-1:0];
    end
  end

  // Effective size: palette_size saturated to MAX_COLORS
  logic [CW+ID_W-1:0] ps_wide;
  logic [CW+ID_W-1:0] eff_wide;
  logic [CW-1:0]      eff_size;

  assign ps_wide  = {{CW{1'b0}}, palette_size};
  assign eff_wide = (ps_wide > MAX_W) ? MAX_W : ps_wide;
  assign eff_size = eff_wide[CW-1:0];

  // Input register
  assign busy = 1'b0;

  logic            item_valid;
  cmd_t            item_cmd;
  logic [ID_W-1:0] item_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_cmd <= cmd_t'(cmd);
      item_id  <= color_id;
    end
  end

  // Pool state
  logic [CW-1:0]         fresh_top,  fresh_top_next;
  logic [IW-1:0]         ring_head,  ring_head_next;
  logic [CW-1:0]         ring_count, ring_count_next;
  logic [MAX_COLORS-1:0] free_mask,  free_mask_next;
  logic [MAX_COLORS-1:0] restart_mask;

  // Ring storage and head prefetch
  logic            ring_we;
  logic [IW-1:0]   ring_waddr;
  logic [ID_W-1:0] ram_rdata;
  logic [ID_W-1:0] ring_rdata;
  logic            byp_valid;
  logic [ID_W-1:0] byp_data;

  cidfp_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_COLORS)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (item_id),
    .raddr (ring_head_next),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= ring_we && (ring_waddr == ring_head_next);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= item_id;
  end

  assign ring_rdata = byp_valid ? byp_data : ram_rdata;

  // Tail = (head + count) mod MAX_COLORS
  logic [CW:0] tail_sum;

  always_comb begin
    tail_sum = {{(CW+1-IW){1'b0}}, ring_head} + {1'b0, ring_count};
    if (tail_sum >= {1'b0, MAX_C}) begin
      tail_sum = tail_sum - {1'b0, MAX_C};
    end
    ring_waddr = tail_sum[IW-1:0];
  end

  // IDs 1..eff_size free after a restart
  always_comb begin
    for (int i = 0; i < MAX_COLORS; i++) begin
      restart_mask[i] = (CW'(i) < eff_size);
    end
  end

  // One pass per command
  logic [ID_W-1:0]    granted_w;
  logic               accepted_w;
  logic [CW+ID_W-1:0] fresh_wide;
  logic [CW+ID_W-1:0] id_wide;
  logic [CW+ID_W-1:0] rd_wide;
  logic [IW-1:0]      free_idx;
  logic [IW-1:0]      pop_idx;
  logic               id_ok;

  always_comb begin
    fresh_top_next  = fresh_top;
    ring_head_next  = ring_head;
    ring_count_next = ring_count;
    free_mask_next  = free_mask;
    granted_w       = '0;
    accepted_w      = 1'b0;
    ring_we         = 1'b0;

    fresh_wide = {{ID_W{1'b0}}, fresh_top};
    id_wide    = {{CW{1'b0}}, item_id};
    rd_wide    = {{CW{1'b0}}, ring_rdata};
    free_idx   = id_to_idx(item_id);
    pop_idx    = id_to_idx(ring_rdata);
    id_ok      = (item_id != '0) && (id_wide <= {{ID_W{1'b0}}, eff_size});

    if (item_valid) begin
      case (item_cmd)
        CMD_RESTART: begin
          free_mask_next  = restart_mask;
          fresh_top_next  = eff_size;
          ring_head_next  = '0;
          ring_count_next = '0;
        end
        CMD_ALLOC: begin
          if (fresh_top != '0) begin
            // never-issued IDs first, from the top down
            granted_w      = fresh_wide[ID_W-1:0];
            fresh_top_next = fresh_top - CW'(1);
            free_mask_next[id_to_idx(fresh_wide[ID_W-1:0])] = 1'b0;
          end else if (ring_count != '0) begin
            // then returned IDs, oldest first
            granted_w       = ring_rdata;
            ring_head_next  = (ring_head == LAST_I) ? '0 : ring_head + IW'(1);
            ring_count_next = ring_count - CW'(1);
            if (ring_rdata != '0 && rd_wide <= MAX_W) begin
              free_mask_next[pop_idx] = 1'b0;
            end
          end
        end
        CMD_FREE: begin
          if (id_ok && !free_mask[free_idx] && ring_count < MAX_C) begin
            ring_we                  = 1'b1;
            ring_count_next          = ring_count + CW'(1);
            free_mask_next[free_idx] = 1'b1;
            accepted_w               = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_top  <= '0;
      ring_head  <= '0;
      ring_count <= '0;
      free_mask  <= '0;
    end else begin
      fresh_top  <= fresh_top_next;
      ring_head  <= ring_head_next;
      ring_count <= ring_count_next;
      free_mask  <= free_mask_next;
    end
  end

  // Result register
  logic [CW+ID_W:0] count_sum;

  assign count_sum = {{(ID_W+1){1'b0}}, fresh_top_next}
                   + {{(ID_W+1){1'b0}}, ring_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    granted_id    <= granted_w;
    free_accepted <= accepted_w;
    free_count    <= count_sum[ID_W-1:0];
  end

  // Checks
  `ASSERT_CLK_RST(a_item_gives_result, clk, rst, item_valid |=> done, "command gave no result")
  `ASSERT_CLK_RST(a_grant_only_on_done, clk, rst, (granted_id != '0) |-> done, "grant outside result")
  `ASSERT_CLK_RST(a_accept_only_on_done, clk, rst, free_accepted |-> done, "accept outside result")
  `ASSERT_CLK_RST(a_pool_bounded, clk, rst, ({1'b0, fresh_top} + {1'b0, ring_count}) <= {1'b0, MAX_C}, "pool holds more IDs than exist")
  `ASSERT_CLK_RST(a_no_grant_and_accept, clk, rst, !(free_accepted && (granted_id != '0)), "grant and accept together")

endmodule
